// ===== sv/rhsi_pkg.sv =====
// shared constants, types and the cordic angle table for the weighted hsi score
// no dependencies
package rhsi_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int CORDIC_STEPS = 28;
	localparam int DIV_STEPS    = FRAC_BITS + 1;
	localparam int HUE_LAT      = CORDIC_STEPS + 1;
	localparam int SAT_LAT      = DIV_STEPS + 1;
	localparam int XW           = 34;
	localparam int ZW           = 35;
	localparam int CW           = 17;

	// reciprocal of 765 rounded up, exact for sums up to 765 after >> 36
	localparam longint unsigned INT_RECIP = ((64'd1 << 36) + 64'd764) / 64'd765;
	localparam logic [26:0] INT_MULT = 27'(INT_RECIP);
	localparam logic [20:0] SQRT3_Q20 = 21'd1816187;
	localparam logic signed [ZW-1:0] QUARTER_TURN = 35'sd1073741824;
	localparam logic signed [ZW-1:0] HALF_TURN    = 35'sd2147483648;

	typedef enum logic [1:0] {
		REG_INT_GAIN = 2'd0,
		REG_HUE_GAIN = 2'd1,
		REG_SAT_GAIN = 2'd2,
		REG_NONE     = 2'd3
	} reg_idx_t;

	typedef logic [CW-1:0] comp_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] a;
		unique case (i)
			5'd0:  a = 32'd536870912;
			5'd1:  a = 32'd316933406;
			5'd2:  a = 32'd167458907;
			5'd3:  a = 32'd85004756;
			5'd4:  a = 32'd42667331;
			5'd5:  a = 32'd21354465;
			5'd6:  a = 32'd10679838;
			5'd7:  a = 32'd5340245;
			5'd8:  a = 32'd2670163;
			5'd9:  a = 32'd1335087;
			5'd10: a = 32'd667544;
			5'd11: a = 32'd333772;
			5'd12: a = 32'd166886;
			5'd13: a = 32'd83443;
			5'd14: a = 32'd41722;
			5'd15: a = 32'd20861;
			5'd16: a = 32'd10430;
			5'd17: a = 32'd5215;
			5'd18: a = 32'd2608;
			5'd19: a = 32'd1304;
			5'd20: a = 32'd652;
			5'd21: a = 32'd326;
			5'd22: a = 32'd163;
			5'd23: a = 32'd81;
			5'd24: a = 32'd41;
			5'd25: a = 32'd20;
			5'd26: a = 32'd10;
			5'd27: a = 32'd5;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

endpackage

// ===== sv/rhsi_hue.sv =====
// pipelined vectoring cordic, one iteration per stage, plus a finishing stage
// depends on rhsi_pkg
module rhsi_hue (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [rhsi_pkg::XW-1:0]    x_in,
	input  logic signed [rhsi_pkg::XW-1:0]    y_in,
	input  logic signed [rhsi_pkg::ZW-1:0]    z_in,
	input  logic                              gray_in,
	input  logic                              mirror_in,
	output rhsi_pkg::comp_t                   hue
);

	localparam int N = rhsi_pkg::CORDIC_STEPS;

	logic signed [rhsi_pkg::XW-1:0] x_s [1:N];
	logic signed [rhsi_pkg::XW-1:0] y_s [1:N];
	logic signed [rhsi_pkg::ZW-1:0] z_s [1:N];
	logic                           gray_s [1:N];
	logic                           mirror_s [1:N];

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_iter
			logic signed [rhsi_pkg::XW-1:0] xi, yi, dx, dy;
			logic signed [rhsi_pkg::ZW-1:0] zi, az;
			logic                           gi, mi;
			if (k == 0) begin : g_first
				assign xi = x_in;
				assign yi = y_in;
				assign zi = z_in;
				assign gi = gray_in;
				assign mi = mirror_in;
			end else begin : g_next
				assign xi = x_s[k];
				assign yi = y_s[k];
				assign zi = z_s[k];
				assign gi = gray_s[k];
				assign mi = mirror_s[k];
			end
			assign dx = yi >>> k;
			assign dy = xi >>> k;
			assign az = $signed({3'b000, rhsi_pkg::atan_turn(5'(k))});
			always_ff @(posedge clk) begin
				if (en) begin
					if (yi >= 0) begin
						x_s[k+1] <= xi + dx;
						y_s[k+1] <= yi - dy;
						z_s[k+1] <= zi + az;
					end else begin
						x_s[k+1] <= xi - dx;
						y_s[k+1] <= yi + dy;
						z_s[k+1] <= zi - az;
					end
					gray_s[k+1]   <= gi;
					mirror_s[k+1] <= mi;
				end
			end
		end
	endgenerate

	// clamp to half a turn, mirror when green exceeds blue
	logic signed [rhsi_pkg::ZW-1:0] zc;
	logic [32:0]                    t;
	always_comb begin
		priority if (gray_s[N])
			zc = rhsi_pkg::QUARTER_TURN;
		else if (z_s[N] < 0)
			zc = '0;
		else if (z_s[N] > rhsi_pkg::HALF_TURN)
			zc = rhsi_pkg::HALF_TURN;
		else
			zc = z_s[N];
		if (mirror_s[N])
			t = 33'h1_0000_0000 - 33'(zc);
		else
			t = 33'(zc);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue <= t[32:32-rhsi_pkg::FRAC_BITS];
		end
	end

endmodule

// ===== sv/rhsi_sat.sv =====
// pipelined restoring divider for 3*min/sum, one quotient bit per stage
// depends on rhsi_pkg
module rhsi_sat (
	input  logic            clk,
	input  logic            en,
	input  logic [9:0]      num_in,
	input  logic [9:0]      den_in,
	output rhsi_pkg::comp_t sat
);

	localparam int N = rhsi_pkg::DIV_STEPS;

	logic [9:0]            rem_s [1:N];
	logic [9:0]            den_s [1:N];
	logic [N-1:0]          quo_s [1:N];

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_step
			logic [9:0]   ri, di;
			logic [N-1:0] qi;
			logic [10:0]  trial;
			if (k == 0) begin : g_first
				assign ri = num_in;
				assign di = den_in;
				assign qi = '0;
				assign trial = {1'b0, ri};
			end else begin : g_next
				assign ri = rem_s[k];
				assign di = den_s[k];
				assign qi = quo_s[k];
				assign trial = {ri, 1'b0};
			end
			always_ff @(posedge clk) begin
				if (en) begin
					if (trial >= {1'b0, di}) begin
						rem_s[k+1] <= 10'(trial - {1'b0, di});
						quo_s[k+1] <= {qi[N-2:0], 1'b1};
					end else begin
						rem_s[k+1] <= trial[9:0];
						quo_s[k+1] <= {qi[N-2:0], 1'b0};
					end
					den_s[k+1] <= di;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			if (den_s[N] == '0)
				sat <= rhsi_pkg::comp_t'(1) << rhsi_pkg::FRAC_BITS;
			else
				sat <= (rhsi_pkg::comp_t'(1) << rhsi_pkg::FRAC_BITS) - quo_s[N];
		end
	end

endmodule

// ===== sv/rgb_to_weighted_hsi_score_top.sv =====
// weighted hsi score of one bgr pixel: front end, hue cordic, saturation divider, score
// depends on rhsi_pkg, rhsi_hue, rhsi_sat
//
//  channel  dir  handshake            payload
//  in       in   in_valid/in_stall    blue, green, red
//  out      out  out_valid/out_stall  score, clipped
//  cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one pixel per cycle unless stalled: two front stages, 29 stages set by the
// 28-step cordic and its finishing stage, three score stages and the output register.
// the whole pipeline holds while the output register is full and out_stall is high.
// arst_n clears the valid bits and loads the default gains.
module rgb_to_weighted_hsi_score_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] blue,
	input  logic [7:0] green,
	input  logic [7:0] red,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] score,
	output logic       clipped,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data
);

	localparam int HL  = rhsi_pkg::HUE_LAT;
	localparam int PAD = rhsi_pkg::HUE_LAT - rhsi_pkg::SAT_LAT;

	logic en;
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	// gains
	logic [9:0] int_gain_q, hue_gain_q, sat_gain_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_gain_q <= 10'd51;
			hue_gain_q <= 10'd128;
			sat_gain_q <= 10'd256;
		end else if (cfg_valid && cfg_ready) begin
			unique case (rhsi_pkg::reg_idx_t'(cfg_index))
				rhsi_pkg::REG_INT_GAIN: int_gain_q <= cfg_data;
				rhsi_pkg::REG_HUE_GAIN: hue_gain_q <= cfg_data;
				rhsi_pkg::REG_SAT_GAIN: sat_gain_q <= cfg_data;
				rhsi_pkg::REG_NONE:     ;
			endcase
		end
	end

	// stage 1: capture pixel
	logic       v_s1;
	logic [7:0] b_s1, g_s1, r_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			b_s1 <= blue;
			g_s1 <= green;
			r_s1 <= red;
		end
	end

	// stage 2: sum, min and cordic start vector
	logic [9:0]                     sum_c, mn3_c;
	logic [7:0]                     mn_c, gb_c;
	logic signed [10:0]             dx_c;
	logic signed [rhsi_pkg::XW-1:0] x0_c, y0_c;
	always_comb begin
		sum_c = 10'(r_s1) + 10'(g_s1) + 10'(b_s1);
		mn_c  = b_s1;
		if (g_s1 < mn_c)
			mn_c = g_s1;
		if (r_s1 < mn_c)
			mn_c = r_s1;
		mn3_c = 10'(mn_c) + 10'({mn_c, 1'b0});
		gb_c  = (g_s1 > b_s1) ? (g_s1 - b_s1) : (b_s1 - g_s1);
		dx_c  = $signed({2'b00, r_s1, 1'b0}) - $signed({3'b000, g_s1}) - $signed({3'b000, b_s1});
		x0_c  = rhsi_pkg::XW'(dx_c) <<< 20;
		y0_c  = $signed({5'b0, 29'(gb_c) * 29'(rhsi_pkg::SQRT3_Q20)});
	end

	logic                           v_s2;
	logic [9:0]                     sum_s2, mn3_s2;
	logic signed [rhsi_pkg::XW-1:0] x_s2, y_s2;
	logic signed [rhsi_pkg::ZW-1:0] z_s2;
	logic                           gray_s2, mirror_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2    <= sum_c;
			mn3_s2    <= mn3_c;
			gray_s2   <= (r_s1 == g_s1) && (g_s1 == b_s1);
			mirror_s2 <= g_s1 > b_s1;
			if (x0_c < 0) begin
				x_s2 <= y0_c;
				y_s2 <= -x0_c;
				z_s2 <= rhsi_pkg::QUARTER_TURN;
			end else begin
				x_s2 <= x0_c;
				y_s2 <= y0_c;
				z_s2 <= '0;
			end
		end
	end

	rhsi_pkg::comp_t hue_w, sat_w;

	rhsi_hue u_hue (
		.clk       (clk),
		.en        (en),
		.x_in      (x_s2),
		.y_in      (y_s2),
		.z_in      (z_s2),
		.gray_in   (gray_s2),
		.mirror_in (mirror_s2),
		.hue       (hue_w)
	);

	rhsi_sat u_sat (
		.clk    (clk),
		.en     (en),
		.num_in (mn3_s2),
		.den_in (sum_s2),
		.sat    (sat_w)
	);

	// alignment of valid, sum and saturation with the hue
	logic            vd_q  [1:HL];
	logic [9:0]      sumd_q [1:HL];
	rhsi_pkg::comp_t satd_q [1:PAD];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= HL; i++)
				vd_q[i] <= 1'b0;
		end else if (en) begin
			vd_q[1] <= v_s2;
			for (int i = 2; i <= HL; i++)
				vd_q[i] <= vd_q[i-1];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sumd_q[1] <= sum_s2;
			for (int i = 2; i <= HL; i++)
				sumd_q[i] <= sumd_q[i-1];
			satd_q[1] <= sat_w;
			for (int i = 2; i <= PAD; i++)
				satd_q[i] <= satd_q[i-1];
		end
	end

	// score stages
	logic            vm1_s1, vm2_s2, vm3_s3;
	rhsi_pkg::comp_t ival_s1, hval_s1, sval_s1;
	logic [36:0]     iprod_c;
	logic [26:0]     pi_s2, ph_s2, ps_s2;
	logic [28:0]     acc_s3;
	logic [36:0]     scaled_c;
	logic [12:0]     v_c;

	assign iprod_c  = 37'(sumd_q[HL]) * 37'(rhsi_pkg::INT_MULT);
	assign scaled_c = {acc_s3, 8'd0} - 37'(acc_s3);
	assign v_c      = scaled_c[36:24];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vm1_s1    <= 1'b0;
			vm2_s2    <= 1'b0;
			vm3_s3    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vm1_s1    <= vd_q[HL];
			vm2_s2    <= vm1_s1;
			vm3_s3    <= vm2_s2;
			out_valid <= vm3_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ival_s1 <= iprod_c[36:36-rhsi_pkg::FRAC_BITS];
			hval_s1 <= hue_w;
			sval_s1 <= satd_q[PAD];
			pi_s2   <= 27'(int_gain_q) * 27'(ival_s1);
			ph_s2   <= 27'(hue_gain_q) * 27'(hval_s1);
			ps_s2   <= 27'(sat_gain_q) * 27'(sval_s1);
			acc_s3  <= 29'(pi_s2) + 29'(ph_s2) + 29'(ps_s2);
			if (v_c > 13'd255) begin
				score   <= 8'd255;
				clipped <= 1'b1;
			end else begin
				score   <= v_c[7:0];
				clipped <= 1'b0;
			end
		end
	end

endmodule

// ===== dv/rgb_to_weighted_hsi_score_top_tb.sv =====
// testbench for rgb_to_weighted_hsi_score_top: directed and random pixels, random idling,
// gain changes between phases, scores predicted by a bit-exact model in the scoreboard class
// depends on rhsi_pkg and rgb_to_weighted_hsi_score_top
`timescale 1ns / 100ps

module rgb_to_weighted_hsi_score_top_tb;

	localparam int LIMIT = 2000000;
	localparam int DRAIN = 60;

	typedef struct packed {
		logic [7:0] score;
		logic       clipped;
	} score_t;

	class hsi_scoreboard;
		logic [9:0] int_gain, hue_gain, sat_gain;
		score_t     pending[$];
		int         errors;

		function new();
			int_gain = 10'd51;
			hue_gain = 10'd128;
			sat_gain = 10'd256;
			errors   = 0;
		endfunction

		function void set_gain(rhsi_pkg::reg_idx_t idx, logic [9:0] d);
			case (idx)
				rhsi_pkg::REG_INT_GAIN: int_gain = d;
				rhsi_pkg::REG_HUE_GAIN: hue_gain = d;
				rhsi_pkg::REG_SAT_GAIN: sat_gain = d;
				default: ;
			endcase
		endfunction

		function longint floor_shift(longint v, int s);
			return v >>> s;
		endfunction

		function longint unsigned hue_of(int r, int g, int b);
			longint x, y, z, t, dx, dy;
			longint unsigned u;
			x = longint'(2 * r - g - b) * (64'sd1 <<< 20);
			y = longint'(g > b ? g - b : b - g) * 1816187;
			if (x == 0 && y == 0) begin
				z = 64'sd1073741824;
			end else begin
				z = 0;
				if (x < 0) begin
					t = x;
					x = y;
					y = -t;
					z = 64'sd1073741824;
				end
				for (int i = 0; i < rhsi_pkg::CORDIC_STEPS; i++) begin
					dx = floor_shift(y, i);
					dy = floor_shift(x, i);
					if (y >= 0) begin
						x += dx;
						y -= dy;
						z += longint'(rhsi_pkg::atan_turn(5'(i)));
					end else begin
						x -= dx;
						y += dy;
						z -= longint'(rhsi_pkg::atan_turn(5'(i)));
					end
				end
				if (z < 0) z = 0;
				if (z > 64'sd2147483648) z = 64'sd2147483648;
			end
			u = longint'(z);
			if (g > b) u = (64'd1 << 32) - u;
			return u >> (32 - rhsi_pkg::FRAC_BITS);
		endfunction

		function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
			longint unsigned one, sum, mn, iv, sv, hv, acc, v;
			score_t e;
			one = 64'd1 << rhsi_pkg::FRAC_BITS;
			sum = r + g + b;
			mn = b;
			if (g < mn) mn = g;
			if (r < mn) mn = r;
			iv = (sum << rhsi_pkg::FRAC_BITS) / 765;
			sv = (sum == 0) ? one : one - (((3 * mn) << rhsi_pkg::FRAC_BITS) / sum);
			hv = hue_of(r, g, b);
			acc = int_gain * iv + hue_gain * hv + sat_gain * sv;
			v = (acc * 255) >> (rhsi_pkg::FRAC_BITS + 8);
			e.score   = (v > 255) ? 8'd255 : v[7:0];
			e.clipped = (v > 255);
			pending.push_back(e);
		endfunction

		function void check_score(logic [7:0] s, logic c);
			score_t e;
			if (pending.size() == 0) begin
				$error("unexpected score transfer: score %0d clipped %0d", s, c);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (s !== e.score) begin
				$error("score: expected %0d, actual %0d", e.score, s);
				errors++;
			end
			if (c !== e.clipped) begin
				$error("clipped: expected %0d, actual %0d", e.clipped, c);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] blue = '0, green = '0, red = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] score;
	logic       clipped;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [9:0] cfg_data = '0;

	hsi_scoreboard sb = new();
	int cycles = 0;
	bit out_idle_off = 1'b0;

	rgb_to_weighted_hsi_score_top dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("rgb_to_weighted_hsi_score_top_tb: done, errors");
			$finish;
		end
	end

	// result side: check transfers, draw a stall length per result
	int stall_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) sb.check_score(score, clipped);
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else if (out_valid && !out_stall && !out_idle_off) begin
				stall_left <= $urandom_range(0, 10);
				out_stall <= ($urandom_range(0, 1) == 1);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// valid stays high after a transfer until the next gap or drain
	task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 10) : 0;
		cfg_valid <= 1'b0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		blue <= b;
		green <= g;
		red <= r;
		do @(posedge clk); while (in_stall);
		sb.note_pixel(b, g, r);
	endtask

	task automatic write_gain(rhsi_pkg::reg_idx_t idx, logic [9:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.set_gain(idx, d);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic random_pixel(bit gaps);
		logic [7:0] v;
		v = 8'($urandom);
		case ($urandom_range(0, 7))
			0: send_pixel(v, v, v, gaps);
			1: send_pixel(v, v, 8'($urandom), gaps);
			2: send_pixel(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
				8'($urandom_range(0, 3)), gaps);
			default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom), gaps);
		endcase
	endtask

	initial begin
		logic [9:0] g0, g1, g2;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, default gains
		send_pixel(8'd0, 8'd0, 8'd0, 0);
		send_pixel(8'd255, 8'd255, 8'd255, 0);
		send_pixel(8'd128, 8'd128, 8'd128, 0);
		send_pixel(8'd0, 8'd0, 8'd255, 0);
		send_pixel(8'd0, 8'd255, 8'd0, 0);
		send_pixel(8'd255, 8'd0, 8'd0, 0);
		send_pixel(8'd0, 8'd255, 8'd255, 0);
		send_pixel(8'd255, 8'd0, 8'd255, 0);
		send_pixel(8'd255, 8'd255, 8'd0, 0);
		send_pixel(8'd40, 8'd40, 8'd200, 0);
		send_pixel(8'd200, 8'd200, 8'd40, 0);
		send_pixel(8'd1, 8'd0, 8'd0, 0);
		send_pixel(8'd0, 8'd1, 8'd0, 0);
		send_pixel(8'd170, 8'd85, 8'd10, 0);
		drain();

		// every gain at its maximum, then at zero, with an ignored index
		write_gain(rhsi_pkg::REG_INT_GAIN, 10'h3FF);
		write_gain(rhsi_pkg::REG_HUE_GAIN, 10'h3FF);
		write_gain(rhsi_pkg::REG_SAT_GAIN, 10'h3FF);
		write_gain(rhsi_pkg::REG_NONE, 10'h155);
		send_pixel(8'd0, 8'd0, 8'd0, 0);
		send_pixel(8'd0, 8'd255, 8'd0, 0);
		send_pixel(8'd255, 8'd255, 8'd255, 0);
		send_pixel(8'd10, 8'd200, 8'd30, 0);
		for (int i = 0; i < 150; i++) random_pixel(1);
		drain();
		write_gain(rhsi_pkg::REG_INT_GAIN, 10'd0);
		write_gain(rhsi_pkg::REG_HUE_GAIN, 10'd0);
		write_gain(rhsi_pkg::REG_SAT_GAIN, 10'd0);
		send_pixel(8'd255, 8'd0, 8'd77, 0);
		for (int i = 0; i < 100; i++) random_pixel(1);
		drain();

		// random phases with random gains, one phase without any idling
		for (int p = 0; p < 6; p++) begin
			g0 = 10'($urandom);
			g1 = 10'($urandom);
			g2 = 10'($urandom);
			write_gain(rhsi_pkg::REG_SAT_GAIN, g2);
			write_gain(rhsi_pkg::REG_INT_GAIN, g0);
			write_gain(rhsi_pkg::REG_HUE_GAIN, g1);
			out_idle_off = (p == 2);
			for (int i = 0; i < 150; i++) begin
				random_pixel(p != 2);
				if (i == 75 && p == 4) drain();
			end
			drain();
		end
		out_idle_off = 1'b0;
		write_gain(rhsi_pkg::REG_INT_GAIN, 10'd51);
		write_gain(rhsi_pkg::REG_HUE_GAIN, 10'd128);
		write_gain(rhsi_pkg::REG_SAT_GAIN, 10'd256);
		for (int i = 0; i < 50; i++) random_pixel(1);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("rgb_to_weighted_hsi_score_top_tb: done, clean");
		end else begin
			$display("rgb_to_weighted_hsi_score_top_tb: done, errors");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
sv/rhsi_pkg.sv
sv/rhsi_hue.sv
sv/rhsi_sat.sv
sv/rgb_to_weighted_hsi_score_top.sv
dv/rgb_to_weighted_hsi_score_top_tb.sv
